// ===== rtl/core/tsrb_pkg.sv =====
package tsrb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int PCT_W      = 7;
  localparam int PIX_W      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  // row position: 100*row, then x and the tanh arguments
  localparam int QX_W       = ROW_W + 7;
  localparam int N_W        = QX_W + 3;
  localparam int PCT_SCALE  = 100;
  localparam int X_OFS      = 50;

  // iterative divider
  localparam int DIV_W      = 64;
  localparam int DEN_W      = 32;
  localparam int CNT_W      = 7;

  // tanh fixed point
  localparam int TERM_W     = 31;
  localparam int SUM_W      = 32;
  localparam int DK_W       = 12;
  localparam int K_W        = 5;
  localparam int K_TERMS    = 24;
  localparam int IP_W       = 6;
  localparam int IP_MAX     = 32;
  localparam int T_W        = 17;
  localparam int A_W        = 17;
  localparam int DF_W       = T_W + 2;
  localparam int DIFF_MAX   = 131072;
  localparam int ACC_W      = A_W + PIX_W + 1;
  localparam int HALF_Q16   = 32768;
  localparam int PIX_MAX    = 255;

  localparam logic [DIV_W-1:0] ONE_Q30  = 64'h4000_0000;
  // truncated 24-term Taylor sum of e^1 in Q30
  localparam logic [DIV_W-1:0] EXP1_Q30 = 64'd2918732883;
  localparam int               EM1_W    = 30;
  localparam logic [EM1_W-1:0] EM1      =
      EM1_W'(((64'd1 << 60) + EXP1_Q30 / 2) / EXP1_Q30);
  localparam logic [A_W-1:0]   ONE_Q16  = 17'h10000;

  localparam logic [PCT_W-1:0] DECAY_RST  = 7'd6;
  localparam logic [PCT_W-1:0] CENTER_RST = 7'd0;
  localparam logic [PCT_W-1:0] BAND_RST   = 7'd20;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY,
    CFG_BAND_CENTER,
    CFG_BAND_HEIGHT,
    CFG_IMAGE_HEIGHT,
    CFG_IMAGE_WIDTH
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_WEIGHT,
    TOP_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    WT_IDLE,
    WT_POS,
    WT_TANH
  } wt_state_e;

  typedef enum logic [3:0] {
    TH_IDLE,
    TH_SPLIT,
    TH_TERM,
    TH_TERM_WAIT,
    TH_INV,
    TH_INV_WAIT,
    TH_POW,
    TH_FIN,
    TH_FIN_WAIT
  } th_state_e;

  typedef struct packed {
    logic [PCT_W-1:0] decay;
    logic [PCT_W-1:0] band_center;
    logic [PCT_W-1:0] band_height;
    logic [DIM_W-1:0] image_height;
    logic [DIM_W-1:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic             frame_start;
    logic [PIX_W-1:0] orig_blue;
    logic [PIX_W-1:0] orig_green;
    logic [PIX_W-1:0] orig_red;
    logic [PIX_W-1:0] blur_blue;
    logic [PIX_W-1:0] blur_green;
    logic [PIX_W-1:0] blur_red;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
  } out_item_t;

endpackage

// ===== rtl/core/tsrb_div.sv =====
module tsrb_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsrb_pkg::DIV_W-1:0]   num_i,
  input  logic [tsrb_pkg::DEN_W-1:0]   den_i,
  input  logic [tsrb_pkg::CNT_W-1:0]   nbits_i,
  output logic                         done_o,
  output logic [tsrb_pkg::DIV_W-1:0]   quo_o,
  output logic [tsrb_pkg::DEN_W-1:0]   rem_o
);
  import tsrb_pkg::*;

  // restoring divider, one quotient bit per cycle; quotient must fit nbits
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      rem_d  = DEN_W'(num_i >> nbits_i);
      num_d  = num_i << (CNT_W'(DIV_W) - nbits_i);
      quo_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      num_d = num_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/tsrb_tanh.sv =====
module tsrb_tanh (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tsrb_pkg::N_W-1:0]   n_i,
  input  logic [tsrb_pkg::PCT_W-1:0]        dv_i,
  output logic                              done_o,
  output logic signed [tsrb_pkg::T_W:0]     tanh_o
);
  import tsrb_pkg::*;

  th_state_e         state_q, state_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [PCT_W-1:0]  dv_q, dv_d;
  logic [PCT_W-1:0]  r_q, r_d;
  logic [IP_W-1:0]   ip_q, ip_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DK_W-1:0]   denk_q, denk_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [TERM_W-1:0] e_q, e_d;
  logic [T_W-1:0]    t_q, t_d;

  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [CNT_W-1:0]  div_nbits;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;

  logic [N_W-1:0]            mag;
  logic [N_W-1:0]            s;
  logic [TERM_W+PCT_W-1:0]   prod_tr;
  logic [TERM_W+EM1_W-1:0]   pow_prod;
  logic [TERM_W-1:0]         e_c;
  logic [TERM_W-1:0]         fin_lo;
  logic [SUM_W-1:0]          fin_den;
  logic [DIV_W-1:0]          fin_num;

  tsrb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .nbits_i (div_nbits),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign mag      = n_i[N_W-1] ? N_W'(-n_i) : N_W'(n_i);
  assign s        = {mag[N_W-2:0], 1'b0};
  assign prod_tr  = (TERM_W+PCT_W)'(term_q) * (TERM_W+PCT_W)'(r_q);
  assign pow_prod = (TERM_W+EM1_W)'(e_q) * (TERM_W+EM1_W)'(EM1)
                  + (TERM_W+EM1_W)'(ONE_Q30 >> 1);
  assign e_c      = (e_q > TERM_W'(ONE_Q30)) ? TERM_W'(ONE_Q30) : e_q;
  assign fin_lo   = TERM_W'(ONE_Q30) - e_c;
  assign fin_den  = SUM_W'(ONE_Q30) + SUM_W'(e_c);
  assign fin_num  = (DIV_W'(fin_lo) << 16) + DIV_W'(fin_den >> 1);

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    done_d    = 1'b0;
    dv_d      = dv_q;
    r_d       = r_q;
    ip_d      = ip_q;
    term_d    = term_q;
    sum_d     = sum_q;
    denk_d    = denk_q;
    k_d       = k_q;
    e_d       = e_q;
    t_d       = t_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_nbits = '0;
    case (state_q)
      TH_IDLE: begin
        if (start_i) begin
          neg_d     = n_i[N_W-1];
          dv_d      = dv_i;
          div_start = 1'b1;
          div_num   = DIV_W'(s);
          div_den   = DEN_W'(dv_i);
          div_nbits = CNT_W'(N_W);
          state_d   = TH_SPLIT;
        end
      end
      TH_SPLIT: begin
        if (div_done) begin
          ip_d    = (div_quo > DIV_W'(IP_MAX)) ? IP_W'(IP_MAX) : div_quo[IP_W-1:0];
          r_d     = div_rem[PCT_W-1:0];
          term_d  = TERM_W'(ONE_Q30);
          sum_d   = SUM_W'(ONE_Q30);
          denk_d  = DK_W'(dv_q);
          k_d     = K_W'(1);
          state_d = TH_TERM;
        end
      end
      TH_TERM: begin
        // a zero term keeps every later term at zero
        if (term_q == '0 || k_q > K_W'(K_TERMS)) begin
          state_d = TH_INV;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(prod_tr);
          div_den   = DEN_W'(denk_q);
          div_nbits = CNT_W'(TERM_W);
          state_d   = TH_TERM_WAIT;
        end
      end
      TH_TERM_WAIT: begin
        if (div_done) begin
          term_d  = div_quo[TERM_W-1:0];
          sum_d   = sum_q + SUM_W'(div_quo[TERM_W-1:0]);
          denk_d  = denk_q + DK_W'(dv_q);
          k_d     = k_q + K_W'(1);
          state_d = TH_TERM;
        end
      end
      TH_INV: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(1) << 60) + DIV_W'(sum_q >> 1);
        div_den   = DEN_W'(sum_q);
        div_nbits = CNT_W'(TERM_W);
        state_d   = TH_INV_WAIT;
      end
      TH_INV_WAIT: begin
        if (div_done) begin
          e_d     = div_quo[TERM_W-1:0];
          state_d = TH_POW;
        end
      end
      TH_POW: begin
        if (ip_q == '0) begin
          state_d = TH_FIN;
        end else begin
          e_d  = pow_prod[30 +: TERM_W];
          ip_d = ip_q - IP_W'(1);
        end
      end
      TH_FIN: begin
        div_start = 1'b1;
        div_num   = fin_num;
        div_den   = DEN_W'(fin_den);
        div_nbits = CNT_W'(T_W);
        state_d   = TH_FIN_WAIT;
      end
      TH_FIN_WAIT: begin
        if (div_done) begin
          t_d     = div_quo[T_W-1:0];
          done_d  = 1'b1;
          state_d = TH_IDLE;
        end
      end
      default: state_d = TH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TH_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dv_q   <= dv_d;
    r_q    <= r_d;
    ip_q   <= ip_d;
    term_q <= term_d;
    sum_q  <= sum_d;
    denk_q <= denk_d;
    k_q    <= k_d;
    e_q    <= e_d;
    t_q    <= t_d;
  end

  assign done_o = done_q;
  assign tanh_o = neg_q ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});

endmodule

// ===== rtl/core/tsrb_weight.sv =====
module tsrb_weight (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsrb_pkg::ROW_W-1:0]  row_i,
  input  tsrb_pkg::cfg_t              cfg_i,
  output logic                        done_o,
  output logic [tsrb_pkg::A_W-1:0]    alpha_o
);
  import tsrb_pkg::*;

  wt_state_e        state_q, state_d;
  logic             done_q, done_d;
  logic [A_W-1:0]   alpha_q, alpha_d;
  logic signed [T_W:0] ta_q, ta_d, tb_q, tb_d;
  logic             ga_q, ga_d, gb_q, gb_d;

  logic [DIM_W-1:0] h_c;
  logic [ROW_W-1:0] hm1;
  logic [PCT_W-1:0] dv;
  logic [QX_W-1:0]  row100;
  logic [PCT_W-1:0] half;

  logic signed [N_W-1:0] x_s, l1_s, l2_s, na, nb;
  logic signed [T_W:0]   ta_v, tb_v;
  logic signed [DF_W-1:0] diff_s;
  logic [DF_W-2:0]       diff_c;
  logic [DF_W-1:0]       diff_r;

  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic             th_start;
  logic             ta_done, tb_done;
  logic signed [T_W:0] ta_out, tb_out;

  assign h_c = (cfg_i.image_height < DIM_W'(2)) ? DIM_W'(2) :
               (cfg_i.image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
               cfg_i.image_height;
  assign hm1    = ROW_W'(h_c - DIM_W'(1));
  assign dv     = (cfg_i.decay == '0) ? PCT_W'(1) : cfg_i.decay;
  assign row100 = QX_W'(row_i) * QX_W'(PCT_SCALE);
  assign half   = cfg_i.band_height >> 1;

  assign x_s  = N_W'(div_quo[QX_W-1:0]) - N_W'(X_OFS);
  assign l1_s = N_W'(cfg_i.band_center) - N_W'(half) - N_W'(X_OFS);
  assign l2_s = N_W'(cfg_i.band_center) + N_W'(half) - N_W'(X_OFS);
  assign na   = x_s - l1_s;
  assign nb   = x_s - l2_s;

  tsrb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DIV_W'(row100)),
    .den_i   (DEN_W'(hm1)),
    .nbits_i (CNT_W'(QX_W)),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   ()
  );

  tsrb_tanh u_tanh_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (th_start),
    .n_i     (na),
    .dv_i    (dv),
    .done_o  (ta_done),
    .tanh_o  (ta_out)
  );

  tsrb_tanh u_tanh_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (th_start),
    .n_i     (nb),
    .dv_i    (dv),
    .done_o  (tb_done),
    .tanh_o  (tb_out)
  );

  // merge of the two lanes
  assign ta_v   = ta_done ? ta_out : ta_q;
  assign tb_v   = tb_done ? tb_out : tb_q;
  assign diff_s = DF_W'(ta_v) - DF_W'(tb_v);
  assign diff_c = (diff_s < 0) ? '0 :
                  (diff_s > DF_W'(DIFF_MAX)) ? (DF_W-1)'(DIFF_MAX) :
                  diff_s[DF_W-2:0];
  assign diff_r = DF_W'(diff_c) + DF_W'(1);

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    alpha_d   = alpha_q;
    ta_d      = ta_q;
    tb_d      = tb_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    div_start = 1'b0;
    th_start  = 1'b0;
    case (state_q)
      WT_IDLE: begin
        if (start_i) begin
          div_start = 1'b1;
          state_d   = WT_POS;
        end
      end
      WT_POS: begin
        if (div_done) begin
          th_start = 1'b1;
          ga_d     = 1'b0;
          gb_d     = 1'b0;
          state_d  = WT_TANH;
        end
      end
      WT_TANH: begin
        if (ta_done) begin
          ta_d = ta_out;
          ga_d = 1'b1;
        end
        if (tb_done) begin
          tb_d = tb_out;
          gb_d = 1'b1;
        end
        if ((ga_q || ta_done) && (gb_q || tb_done)) begin
          alpha_d = A_W'(diff_r >> 1);
          done_d  = 1'b1;
          state_d = WT_IDLE;
        end
      end
      default: state_d = WT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WT_IDLE;
      done_q  <= 1'b0;
      ga_q    <= 1'b0;
      gb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ga_q    <= ga_d;
      gb_q    <= gb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
    ta_q    <= ta_d;
    tb_q    <= tb_d;
  end

  assign done_o  = done_q;
  assign alpha_o = alpha_q;

endmodule

// ===== rtl/core/tsrb_lane.sv =====
module tsrb_lane (
  input  logic [tsrb_pkg::PIX_W-1:0] orig_i,
  input  logic [tsrb_pkg::PIX_W-1:0] blur_i,
  input  logic [tsrb_pkg::A_W-1:0]   alpha_i,
  output logic [tsrb_pkg::PIX_W-1:0] px_o
);
  import tsrb_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-17:0] v;

  assign acc = ACC_W'(alpha_i) * ACC_W'(orig_i)
             + ACC_W'(ONE_Q16 - alpha_i) * ACC_W'(blur_i)
             + ACC_W'(HALF_Q16);
  assign v    = acc[ACC_W-1:16];
  assign px_o = (v > (ACC_W-16)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : v[PIX_W-1:0];

endmodule

// ===== rtl/core/tilt_shift_row_blend.sv =====
// An item that is not at a row start is registered into the output in the cycle after acceptance.
// A row-start item (column 0 or frame_start) first recomputes the row weight: a row-position
// divide, then in each tanh lane a split divide, one divide per Taylor term, an inverse and a final divide.
// Throughput: one item per cycle within a row while the output is taken.
// Reset: counters clear, config registers take their defaults, output empty; no clearing pass.
module tilt_shift_row_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tsrb_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tsrb_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [tsrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsrb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tsrb_pkg::*;

  top_state_e       state_q, state_d;
  cfg_t             cfg_q;
  logic [COL_W-1:0] column_count_q, column_count_d;
  logic [ROW_W-1:0] row_count_q, row_count_d;
  logic [A_W-1:0]   row_weight_q, row_weight_d;
  in_item_t         pix_q, pix_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             out_free;
  logic             accept;
  logic             out_load;
  logic [DIM_W-1:0] w_c, h_c;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [DIM_W-1:0] col_inc, row_inc;
  in_item_t         src;
  out_item_t        blend_res;
  logic             wt_start;
  logic             wt_done;
  logic [A_W-1:0]   wt_alpha;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == TOP_IDLE && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign w_c = (cfg_q.image_width == '0) ? DIM_W'(1) :
               (cfg_q.image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) :
               cfg_q.image_width;
  assign h_c = (cfg_q.image_height < DIM_W'(2)) ? DIM_W'(2) :
               (cfg_q.image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
               cfg_q.image_height;

  assign col_cur = in_item_i.frame_start ? '0 : column_count_q;
  assign row_cur = in_item_i.frame_start ? '0 : row_count_q;
  assign col_inc = DIM_W'(col_cur) + DIM_W'(1);
  assign row_inc = DIM_W'(row_cur) + DIM_W'(1);

  assign src = (state_q == TOP_EMIT) ? pix_q : in_item_i;

  tsrb_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wt_start),
    .row_i   (row_cur),
    .cfg_i   (cfg_q),
    .done_o  (wt_done),
    .alpha_o (wt_alpha)
  );

  tsrb_lane u_lane_blue (
    .orig_i  (src.orig_blue),
    .blur_i  (src.blur_blue),
    .alpha_i (row_weight_q),
    .px_o    (blend_res.out_blue)
  );

  tsrb_lane u_lane_green (
    .orig_i  (src.orig_green),
    .blur_i  (src.blur_green),
    .alpha_i (row_weight_q),
    .px_o    (blend_res.out_green)
  );

  tsrb_lane u_lane_red (
    .orig_i  (src.orig_red),
    .blur_i  (src.blur_red),
    .alpha_i (row_weight_q),
    .px_o    (blend_res.out_red)
  );

  always_comb begin
    state_d        = state_q;
    column_count_d = column_count_q;
    row_count_d    = row_count_q;
    row_weight_d   = row_weight_q;
    pix_d          = pix_q;
    out_d          = out_q;
    out_load       = 1'b0;
    wt_start       = 1'b0;
    case (state_q)
      TOP_IDLE: begin
        if (accept) begin
          if (col_inc >= w_c) begin
            column_count_d = '0;
            row_count_d    = (row_inc >= h_c) ? '0 : row_inc[ROW_W-1:0];
          end else begin
            column_count_d = col_inc[COL_W-1:0];
            row_count_d    = row_cur;
          end
          if (col_cur == '0) begin
            pix_d    = in_item_i;
            wt_start = 1'b1;
            state_d  = TOP_WEIGHT;
          end else begin
            out_d    = blend_res;
            out_load = 1'b1;
          end
        end
      end
      TOP_WEIGHT: begin
        if (wt_done) begin
          row_weight_d = wt_alpha;
          state_d      = TOP_EMIT;
        end
      end
      TOP_EMIT: begin
        if (out_free) begin
          out_d    = blend_res;
          out_load = 1'b1;
          state_d  = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= TOP_IDLE;
      column_count_q       <= '0;
      row_count_q          <= '0;
      out_valid_q          <= 1'b0;
      cfg_q.decay          <= DECAY_RST;
      cfg_q.band_center    <= CENTER_RST;
      cfg_q.band_height    <= BAND_RST;
      cfg_q.image_height   <= HEIGHT_RST;
      cfg_q.image_width    <= WIDTH_RST;
    end else begin
      state_q        <= state_d;
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DECAY:        cfg_q.decay        <= cfg_wdata_i[PCT_W-1:0];
          CFG_BAND_CENTER:  cfg_q.band_center  <= cfg_wdata_i[PCT_W-1:0];
          CFG_BAND_HEIGHT:  cfg_q.band_height  <= cfg_wdata_i[PCT_W-1:0];
          CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i[DIM_W-1:0];
          CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_weight_q <= row_weight_d;
    pix_q        <= pix_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_wdone_in_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wt_done |-> state_q == TOP_WEIGHT)
    else $error("weight done outside weight state");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == TOP_EMIT && out_free |=> out_valid_q && state_q == TOP_IDLE)
    else $error("held row-start item not emitted");

  a_row_start_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && col_cur == '0 |=> state_q == TOP_WEIGHT)
    else $error("row-start item skipped weight update");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.frame_start |=> column_count_q <= COL_W'(1))
    else $error("frame start did not restart column count");

endmodule
